/* hdl/aau_pkg.sv */
`timescale 1ns / 1ps
// Package for the annealing acceptance unit: field widths, config layout,
// register index codes and the status struct. No dependencies.
package aau_pkg;

	// Default widths of the cost and tag fields
	localparam int COST_WIDTH_DEF = 32;
	localparam int TAG_WIDTH_DEF  = 16;

	// Fixed-point formats
	localparam int FRAC_W  = 16;               // fractional bits of temperature and ratio
	localparam int TEMP_W  = 32;               // temperature, unsigned Q16.16
	localparam int NLU_W   = 24;               // -ln(u), unsigned Q8.16
	localparam int RATIO_W = 16;               // cooling ratio, unsigned Q0.16
	localparam int PROD_W  = TEMP_W + NLU_W;   // exact acceptance product
	localparam int COOL_W  = TEMP_W + RATIO_W; // cooling product
	localparam int THR_W   = PROD_W - FRAC_W;  // acceptance threshold

	// Counters
	localparam int MAXIT_W    = 24;
	localparam int IPT_W      = 16;
	localparam int ITER_CNT_W = MAXIT_W + 1;
	localparam int STEP_CNT_W = IPT_W + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INIT_TEMP = 2'd0,
		REG_COOL_RATIO = 2'd1,
		REG_MAX_ITER  = 2'd2,
		REG_ITER_PER_T = 2'd3
	} cfg_reg_t;

	localparam logic [TEMP_W-1:0]  INIT_TEMP_RST = TEMP_W'(6553600);
	localparam logic [RATIO_W-1:0] RATIO_RST     = RATIO_W'(62259);
	localparam logic [MAXIT_W-1:0] MAX_ITER_RST  = MAXIT_W'(1000);
	localparam logic [IPT_W-1:0]   IPT_RST       = IPT_W'(100);

	typedef struct packed {
		logic [TEMP_W-1:0]  init_temp;
		logic [RATIO_W-1:0] ratio;
		logic [MAXIT_W-1:0] max_iter;
		logic [IPT_W-1:0]   iter_per_t;
	} aau_cfg_t;

	typedef struct packed {
		logic accepted;
		logic finished;
	} aau_status_t;

endpackage

/* hdl/aau_metropolis.sv */
`timescale 1ns / 1ps
// Metropolis acceptance test: ((new-old)<<16) < temperature*neg_log_uniform.
// Depends on aau_pkg.
module aau_metropolis #(
	parameter int COST_WIDTH = aau_pkg::COST_WIDTH_DEF
) (
	input  logic signed [COST_WIDTH-1:0]  cand_cost,
	input  logic signed [COST_WIDTH-1:0]  cur_cost,
	input  logic [aau_pkg::TEMP_W-1:0]    temp,
	input  logic [aau_pkg::NLU_W-1:0]     nlu,
	output logic                          take
);
	import aau_pkg::*;

	localparam int CMP_W = (COST_WIDTH > THR_W) ? COST_WIDTH : THR_W;

	logic                  lower;
	logic [COST_WIDTH-1:0] delta;
	logic [PROD_W-1:0]     prod;
	logic [PROD_W-1:0]     prod_m1;
	logic [CMP_W-1:0]      delta_ext;
	logic [CMP_W-1:0]      thr_ext;

	assign lower     = cand_cost < cur_cost;
	// non-negative whenever it is used, so it fits in COST_WIDTH unsigned bits
	assign delta     = COST_WIDTH'(cand_cost - cur_cost);
	assign prod      = PROD_W'(temp) * PROD_W'(nlu);
	assign prod_m1   = prod - PROD_W'(1);
	// delta*2^16 < P  <=>  P /= 0 and delta <= (P-1)>>16
	assign delta_ext = CMP_W'(delta);
	assign thr_ext   = CMP_W'(prod_m1[PROD_W-1:FRAC_W]);
	assign take      = lower || ((prod != '0) && (delta_ext <= thr_ext));

endmodule

/* hdl/aau_state.sv */
`timescale 1ns / 1ps
// Search state: current and best points, temperature, counters and done flag,
// with their per-transaction update. Depends on aau_pkg and aau_metropolis.
module aau_state #(
	parameter int COST_WIDTH = aau_pkg::COST_WIDTH_DEF,
	parameter int TAG_WIDTH  = aau_pkg::TAG_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd_en,
	input  aau_pkg::aau_cfg_t             cfg,
	input  logic                          start,
	input  logic signed [COST_WIDTH-1:0]  cand_cost,
	input  logic [TAG_WIDTH-1:0]          cand_tag,
	input  logic [aau_pkg::NLU_W-1:0]     nlu,
	output aau_pkg::aau_status_t          status,
	output logic signed [COST_WIDTH-1:0]  cur_cost_nx,
	output logic [TAG_WIDTH-1:0]          cur_tag_nx,
	output logic signed [COST_WIDTH-1:0]  best_cost_nx,
	output logic [TAG_WIDTH-1:0]          best_tag_nx,
	output logic [aau_pkg::TEMP_W-1:0]    temp_nx
);
	import aau_pkg::*;

	localparam logic [COST_WIDTH-1:0] COST_MAX = {1'b0, {(COST_WIDTH-1){1'b1}}};

	logic signed [COST_WIDTH-1:0] cur_cost_q;
	logic [TAG_WIDTH-1:0]         cur_tag_q;
	logic signed [COST_WIDTH-1:0] best_cost_q;
	logic [TAG_WIDTH-1:0]         best_tag_q;
	logic [TEMP_W-1:0]            temp_q;
	logic [ITER_CNT_W-1:0]        iter_q, iter_nx;
	logic [STEP_CNT_W-1:0]        step_q, step_nx, step_inc;
	logic                         done_q, done_nx;
	logic                         take;
	logic [COOL_W-1:0]            cool_prod;

	aau_metropolis #(
		.COST_WIDTH(COST_WIDTH)
	) u_metropolis (
		.cand_cost(cand_cost),
		.cur_cost (cur_cost_q),
		.temp     (temp_q),
		.nlu      (nlu),
		.take     (take)
	);

	assign cool_prod = COOL_W'(temp_q) * COOL_W'(cfg.ratio);
	assign step_inc  = step_q + STEP_CNT_W'(1);

	always_comb begin
		cur_cost_nx     = cur_cost_q;
		cur_tag_nx      = cur_tag_q;
		best_cost_nx    = best_cost_q;
		best_tag_nx     = best_tag_q;
		temp_nx         = temp_q;
		iter_nx         = iter_q;
		step_nx         = step_q;
		done_nx         = done_q;
		status.accepted = 1'b0;
		priority if (start) begin
			cur_cost_nx     = cand_cost;
			cur_tag_nx      = cand_tag;
			best_cost_nx    = cand_cost;
			best_tag_nx     = cand_tag;
			temp_nx         = cfg.init_temp;
			iter_nx         = '0;
			step_nx         = '0;
			done_nx         = 1'b0;
			status.accepted = 1'b1;
		end else if (!done_q) begin
			status.accepted = take;
			if (take) begin
				cur_cost_nx = cand_cost;
				cur_tag_nx  = cand_tag;
			end
			// compare uses the count before increment
			if (iter_q > ITER_CNT_W'(cfg.max_iter))
				done_nx = 1'b1;
			if (iter_q != '1)
				iter_nx = iter_q + ITER_CNT_W'(1);
			if (step_inc > STEP_CNT_W'(cfg.iter_per_t)) begin
				step_nx = '0;
				temp_nx = cool_prod[FRAC_W +: TEMP_W];
			end else begin
				step_nx = step_inc;
			end
			if (cand_cost < best_cost_q) begin
				best_cost_nx = cand_cost;
				best_tag_nx  = cand_tag;
			end
		end
		status.finished = done_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cost_q  <= '0;
			cur_tag_q   <= '0;
			best_cost_q <= COST_MAX;
			best_tag_q  <= '0;
			temp_q      <= '0;
			iter_q      <= '0;
			step_q      <= '0;
			done_q      <= 1'b0;
		end else if (upd_en) begin
			cur_cost_q  <= cur_cost_nx;
			cur_tag_q   <= cur_tag_nx;
			best_cost_q <= best_cost_nx;
			best_tag_q  <= best_tag_nx;
			temp_q      <= temp_nx;
			iter_q      <= iter_nx;
			step_q      <= step_nx;
			done_q      <= done_nx;
		end
	end

endmodule

/* hdl/annealing_acceptance_unit.sv */
`timescale 1ns / 1ps
// Top level of the annealing acceptance unit: config registers, input and
// result registers, handshake. Depends on aau_pkg and aau_state.
//
//  channel    | handshake              | payload
//  -----------+------------------------+-------------------------------------------
//  candidate  | cand_valid / cand_stall| start_req, candidate_cost, candidate_tag,
//             |                        | neg_log_uniform
//  result     | res_valid / res_stall  | accepted, current_cost, current_tag,
//             |                        | best_cost, best_tag, temperature_now, finished
//  config     | cfg_wr_en              | cfg_index, cfg_data
//
// One transaction per cycle sustained while res_stall is low; a candidate passes the
// input register, then the result register, from which its result is offered.
// The path that sets the cycle is the 32x24 acceptance multiply and its compare
// against the cost difference, both reading the state registers.
// Reset clears the search state, but sets best cost to its maximum, and loads the config defaults;
// temperature is zero until a start transaction.
// A stalled result holds the result register; the input register still takes
// one more candidate, after which cand_stall follows res_stall.
module annealing_acceptance_unit #(
	parameter int COST_WIDTH = aau_pkg::COST_WIDTH_DEF,
	parameter int TAG_WIDTH  = aau_pkg::TAG_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_wr_en,
	input  logic [aau_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aau_pkg::CFG_DATA_W-1:0]   cfg_data,
	// candidate channel
	input  logic                             cand_valid,
	output logic                             cand_stall,
	input  logic                             start_req,
	input  logic signed [COST_WIDTH-1:0]     candidate_cost,
	input  logic [TAG_WIDTH-1:0]             candidate_tag,
	input  logic [aau_pkg::NLU_W-1:0]        neg_log_uniform,
	// result channel
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic                             accepted,
	output logic signed [COST_WIDTH-1:0]     current_cost,
	output logic [TAG_WIDTH-1:0]             current_tag,
	output logic signed [COST_WIDTH-1:0]     best_cost,
	output logic [TAG_WIDTH-1:0]             best_tag,
	output logic [aau_pkg::TEMP_W-1:0]       temperature_now,
	output logic                             finished
);
	import aau_pkg::*;

	aau_cfg_t cfg_q;

	// input register
	logic                         valid_s1;
	logic                         start_s1;
	logic signed [COST_WIDTH-1:0] cost_s1;
	logic [TAG_WIDTH-1:0]         tag_s1;
	logic [NLU_W-1:0]             nlu_s1;

	// result register
	logic                         valid_s2;
	logic                         acc_s2;
	logic signed [COST_WIDTH-1:0] cur_cost_s2;
	logic [TAG_WIDTH-1:0]         cur_tag_s2;
	logic signed [COST_WIDTH-1:0] best_cost_s2;
	logic [TAG_WIDTH-1:0]         best_tag_s2;
	logic [TEMP_W-1:0]            temp_s2;
	logic                         fin_s2;

	logic                         advance;
	logic                         cand_take;
	aau_status_t                  status;
	logic signed [COST_WIDTH-1:0] cur_cost_nx;
	logic [TAG_WIDTH-1:0]         cur_tag_nx;
	logic signed [COST_WIDTH-1:0] best_cost_nx;
	logic [TAG_WIDTH-1:0]         best_tag_nx;
	logic [TEMP_W-1:0]            temp_nx;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_temp  <= INIT_TEMP_RST;
			cfg_q.ratio      <= RATIO_RST;
			cfg_q.max_iter   <= MAX_ITER_RST;
			cfg_q.iter_per_t <= IPT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INIT_TEMP:  cfg_q.init_temp  <= cfg_data[TEMP_W-1:0];
				REG_COOL_RATIO: cfg_q.ratio      <= cfg_data[RATIO_W-1:0];
				REG_MAX_ITER:   cfg_q.max_iter   <= cfg_data[MAXIT_W-1:0];
				REG_ITER_PER_T: cfg_q.iter_per_t <= cfg_data[IPT_W-1:0];
			endcase
		end
	end

	// the item in s1 moves on (and updates the state) when the result slot frees
	assign advance    = valid_s1 && (!valid_s2 || !res_stall);
	assign cand_stall = valid_s1 && valid_s2 && res_stall;
	assign cand_take  = cand_valid && !cand_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cand_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_take) begin
			start_s1 <= start_req;
			cost_s1  <= candidate_cost;
			tag_s1   <= candidate_tag;
			nlu_s1   <= neg_log_uniform;
		end
	end

	aau_state #(
		.COST_WIDTH(COST_WIDTH),
		.TAG_WIDTH (TAG_WIDTH)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd_en      (advance),
		.cfg         (cfg_q),
		.start       (start_s1),
		.cand_cost   (cost_s1),
		.cand_tag    (tag_s1),
		.nlu         (nlu_s1),
		.status      (status),
		.cur_cost_nx (cur_cost_nx),
		.cur_tag_nx  (cur_tag_nx),
		.best_cost_nx(best_cost_nx),
		.best_tag_nx (best_tag_nx),
		.temp_nx     (temp_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			acc_s2       <= status.accepted;
			cur_cost_s2  <= cur_cost_nx;
			cur_tag_s2   <= cur_tag_nx;
			best_cost_s2 <= best_cost_nx;
			best_tag_s2  <= best_tag_nx;
			temp_s2      <= temp_nx;
			fin_s2       <= status.finished;
		end
	end

	assign res_valid       = valid_s2;
	assign accepted        = acc_s2;
	assign current_cost    = cur_cost_s2;
	assign current_tag     = cur_tag_s2;
	assign best_cost       = best_cost_s2;
	assign best_tag        = best_tag_s2;
	assign temperature_now = temp_s2;
	assign finished        = fin_s2;

	// a stalled result stays offered with its payload unchanged
	a_res_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_stall) |=> (valid_s2 && $stable(acc_s2) && $stable(cur_cost_s2)
			&& $stable(cur_tag_s2) && $stable(best_cost_s2) && $stable(best_tag_s2)
			&& $stable(temp_s2) && $stable(fin_s2)))
		else $error("stalled result changed");

	// a taken candidate always lands in the input register
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cand_take |=> valid_s1)
		else $error("candidate taken but input register empty");

	// an item held in s1 keeps its payload until it moves on
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(cost_s1) && $stable(tag_s1)
			&& $stable(nlu_s1) && $stable(start_s1)))
		else $error("held item in input register changed");

endmodule
